// ----- rtl/mcr_pkg.sv -----
// ----------------------------------------------------------------------------
// mcr_pkg
// shared widths, register indexes and defaults of the miss curve resampler
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int BUCKET_W        = 6;   // bucket counts and point indexes
    localparam int COUNT_W         = 32;  // miss counts
    localparam int NUM_W           = COUNT_W + BUCKET_W; // interpolation numerator
    localparam int MAX_BUCKETS_DEF = 32;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_BUCKETS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_BUCKETS = 1'b1;

    localparam logic [BUCKET_W-1:0] BUCKETS_RST = 6'd16;

endpackage

// ----- rtl/mcr_div.sv -----
// ----------------------------------------------------------------------------
// mcr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mcr_div #(
    parameter int DW = mcr_pkg::NUM_W,
    parameter int VW = mcr_pkg::BUCKET_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);

    localparam int SW = $clog2(DW + 1);

    logic          r_busy;
    logic [SW-1:0] r_step;
    logic [DW-1:0] r_quot;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    // shift the next dividend bit into the partial remainder
    assign trial = {r_rem, r_quot[DW-1]};
    assign ge    = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == SW'(DW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[VW-1:0] : trial[VW-1:0];
            r_quot <= {r_quot[DW-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/mcr_mac.sv -----
// ----------------------------------------------------------------------------
// mcr_mac
// multiply-accumulate for the interpolation numerator a*(R-k) + b*k
// ----------------------------------------------------------------------------
module mcr_mac (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic                         i_acc,
    input  logic [mcr_pkg::COUNT_W-1:0]  i_a,
    input  logic [mcr_pkg::BUCKET_W-1:0] i_b,
    output logic [mcr_pkg::NUM_W-1:0]    o_sum
);

    logic [mcr_pkg::NUM_W-1:0] prod;
    logic [mcr_pkg::NUM_W-1:0] r_sum;

    assign prod = mcr_pkg::NUM_W'(i_a) * mcr_pkg::NUM_W'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum <= prod;
        end else if (i_acc) begin
            r_sum <= r_sum + prod;
        end
    end

    assign o_sum = r_sum;

endmodule

// ----- rtl/miss_curve_resampler.sv -----
// ----------------------------------------------------------------------------
// miss_curve_resampler
// resamples a miss curve point by point: decimation when the source has at
// least as many buckets as the destination, linear interpolation otherwise
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//  input    | i_in_valid/o_in_stall   | i_curve_point
//  output   | o_out_valid/i_out_stall | o_bucket_index, o_resampled_count,
//           |                         | o_end_of_curve, o_ratio_error
//
//  every item is accepted in ST_IDLE, then waits in ST_RATIO for the ratio division
//  decimation adds an index/ratio division and a keep/emit step, but not on the final point
//  interpolation passes these steps per emitted point: two mac steps, a divider
//  start step, the wait in the divider, one output step
//  ST_DONE advances the point counter, the final point first passes ST_LAST to be emitted
//  o_in_stall is high until the item is done, a stalled output holds the emit state
// ----------------------------------------------------------------------------
module miss_curve_resampler #(
    parameter int MAX_BUCKETS = mcr_pkg::MAX_BUCKETS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mcr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mcr_pkg::BUCKET_W-1:0]   i_cfg_data,
    // source points
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [mcr_pkg::COUNT_W-1:0]    i_curve_point,
    // resampled points
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [mcr_pkg::BUCKET_W-1:0]   o_bucket_index,
    output logic [mcr_pkg::COUNT_W-1:0]    o_resampled_count,
    output logic                           o_end_of_curve,
    output logic                           o_ratio_error
);

    localparam int BW = mcr_pkg::BUCKET_W;
    localparam int CW = mcr_pkg::COUNT_W;
    localparam int NW = mcr_pkg::NUM_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RATIO  = 4'd1;  // wait for max/min division
    localparam logic [3:0] ST_DECDIV = 4'd2;  // wait for index/ratio division
    localparam logic [3:0] ST_DECOUT = 4'd3;  // emit kept point if any
    localparam logic [3:0] ST_MUL1   = 4'd4;  // a*(R-k)
    localparam logic [3:0] ST_MUL2   = 4'd5;  // + b*k
    localparam logic [3:0] ST_INTGO  = 4'd6;  // start numerator division
    localparam logic [3:0] ST_INTDIV = 4'd7;
    localparam logic [3:0] ST_INTOUT = 4'd8;  // emit interpolated point
    localparam logic [3:0] ST_LAST   = 4'd9;  // emit final point
    localparam logic [3:0] ST_DONE   = 4'd10; // advance point counter

    localparam logic [BW-1:0] MAX_B = BW'(MAX_BUCKETS);

    // configuration registers
    logic [BW-1:0] r_src_cfg;
    logic [BW-1:0] r_dst_cfg;

    // per-item working registers
    logic [3:0]    r_state;
    logic [3:0]    n_state;
    logic [CW-1:0] r_point;
    logic [CW-1:0] r_prev;
    logic [BW-1:0] r_pcnt;      // index of current source point
    logic [BW-1:0] r_ratio;     // latched at point 0
    logic [BW-1:0] r_reff;      // ratio, zero read as one
    logic [BW-1:0] r_d;
    logic          r_down;
    logic          r_last;
    logic          r_err;
    logic [BW-1:0] r_k;
    logic [BW-1:0] r_base;      // R*(i-1), wraps to 6 bits

    // output register
    logic          r_out_valid;
    logic [BW-1:0] r_out_idx;
    logic [CW-1:0] r_out_cnt;
    logic          r_out_end;
    logic          r_out_err;

    logic          in_accept;
    logic          out_free;
    logic [BW-1:0] s_eff;
    logic [BW-1:0] d_eff;
    logic          down_now;

    // divider hookup
    logic          div_start;
    logic [NW-1:0] div_dividend;
    logic [BW-1:0] div_divisor;
    logic          div_busy;
    logic [NW-1:0] div_quot;
    logic [BW-1:0] div_rem;

    // mac hookup
    logic          mac_load;
    logic          mac_acc;
    logic [CW-1:0] mac_a;
    logic [BW-1:0] mac_b;
    logic [NW-1:0] mac_sum;

    // emit request from the sequencer
    logic          emit;
    logic [BW-1:0] emit_idx;
    logic [CW-1:0] emit_cnt;
    logic          emit_end;

    logic [BW-1:0]   ratio_new;
    logic [BW-1:0]   reff_new;
    logic [2*BW-1:0] base_prod;
    logic            dec_keep;

    // clamp bucket counts into 1..MAX_BUCKETS
    function automatic logic [BW-1:0] eff_buckets(input logic [BW-1:0] v,
                                                  input logic [BW-1:0] vmax);
        logic [BW-1:0] res;
        if (v == '0) begin
            res = BW'(1);
        end else if (v > vmax) begin
            res = vmax;
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign s_eff    = eff_buckets(r_src_cfg, MAX_B);
    assign d_eff    = eff_buckets(r_dst_cfg, MAX_B);
    assign down_now = (s_eff >= d_eff);

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    // the ratio is taken fresh on point 0 and held for the rest of the curve
    assign ratio_new = (r_pcnt == '0) ? div_quot[BW-1:0] : r_ratio;
    assign reff_new  = (ratio_new == '0) ? BW'(1) : ratio_new;
    assign base_prod = reff_new * (r_pcnt - BW'(1));
    assign dec_keep  = (div_rem == '0) && (div_quot < NW'(r_d));

    mcr_div #(
        .DW (NW),
        .VW (BW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    mcr_mac u_mac (
        .i_clk  (i_clk),
        .i_load (mac_load),
        .i_acc  (mac_acc),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .o_sum  (mac_sum)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = NW'(r_pcnt);
        div_divisor  = reff_new;
        mac_load     = 1'b0;
        mac_acc      = 1'b0;
        mac_a        = r_prev;
        mac_b        = r_reff - r_k;
        emit         = 1'b0;
        emit_idx     = r_d;
        emit_cnt     = r_point;
        emit_end     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    // larger count over smaller one
                    div_start    = 1'b1;
                    div_dividend = down_now ? NW'(s_eff) : NW'(d_eff);
                    div_divisor  = down_now ? d_eff : s_eff;
                    n_state      = ST_RATIO;
                end
            end
            ST_RATIO: begin
                if (!div_busy) begin
                    if (r_down) begin
                        if (r_last) begin
                            n_state = ST_LAST;
                        end else begin
                            div_start = 1'b1;
                            n_state   = ST_DECDIV;
                        end
                    end else if (r_pcnt != '0) begin
                        n_state = ST_MUL1;
                    end else begin
                        n_state = r_last ? ST_LAST : ST_DONE;
                    end
                end
            end
            ST_DECDIV: begin
                if (!div_busy) begin
                    n_state = ST_DECOUT;
                end
            end
            ST_DECOUT: begin
                if (!dec_keep) begin
                    n_state = r_last ? ST_LAST : ST_DONE;
                end else if (out_free) begin
                    emit     = 1'b1;
                    emit_idx = div_quot[BW-1:0];
                    n_state  = r_last ? ST_LAST : ST_DONE;
                end
            end
            ST_MUL1: begin
                mac_load = 1'b1;
                n_state  = ST_MUL2;
            end
            ST_MUL2: begin
                mac_acc = 1'b1;
                mac_a   = r_point;
                mac_b   = r_k;
                n_state = ST_INTGO;
            end
            ST_INTGO: begin
                div_start    = 1'b1;
                div_dividend = mac_sum;
                div_divisor  = r_reff;
                n_state      = ST_INTDIV;
            end
            ST_INTDIV: begin
                if (!div_busy) begin
                    n_state = ST_INTOUT;
                end
            end
            ST_INTOUT: begin
                if (out_free) begin
                    emit     = 1'b1;
                    emit_idx = r_base + r_k;
                    emit_cnt = div_quot[CW-1:0];
                    if (r_k == r_reff - BW'(1)) begin
                        n_state = r_last ? ST_LAST : ST_DONE;
                    end else begin
                        n_state = ST_MUL1;
                    end
                end
            end
            ST_LAST: begin
                if (out_free) begin
                    emit     = 1'b1;
                    emit_end = 1'b1;
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_src_cfg   <= mcr_pkg::BUCKETS_RST;
            r_dst_cfg   <= mcr_pkg::BUCKETS_RST;
            r_prev      <= '0;
            r_pcnt      <= '0;
            r_ratio     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mcr_pkg::CFG_SRC_BUCKETS: r_src_cfg <= i_cfg_data;
                    mcr_pkg::CFG_DST_BUCKETS: r_dst_cfg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_RATIO && !div_busy) begin
                r_ratio <= ratio_new;
            end
            if (r_state == ST_DONE) begin
                r_prev <= r_point;
                r_pcnt <= r_last ? '0 : r_pcnt + BW'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-item payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_point <= i_curve_point;
            r_d     <= d_eff;
            r_down  <= down_now;
            r_last  <= (r_pcnt >= s_eff);
        end
        if (r_state == ST_RATIO && !div_busy) begin
            r_err  <= (div_rem != '0);
            r_reff <= reff_new;
            r_base <= base_prod[BW-1:0];
            r_k    <= '0;
        end
        if (r_state == ST_INTOUT && out_free) begin
            r_k <= r_k + BW'(1);
        end
        if (emit) begin
            r_out_idx <= emit_idx;
            r_out_cnt <= emit_cnt;
            r_out_end <= emit_end;
            r_out_err <= r_err;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_bucket_index    = r_out_idx;
    assign o_resampled_count = r_out_cnt;
    assign o_end_of_curve    = r_out_end;
    assign o_ratio_error     = r_out_err;

endmodule

// ----- dv/miss_curve_resampler_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// miss_curve_resampler_tb
// directed and random curves under several idling patterns, each output item
// checked field by field against the oldest expected point
// ----------------------------------------------------------------------------
module miss_curve_resampler_tb;

    localparam int BW            = mcr_pkg::BUCKET_W;
    localparam int CW            = mcr_pkg::COUNT_W;
    localparam int CIW           = mcr_pkg::CFG_IDX_W;
    localparam int MAX_BKT       = mcr_pkg::MAX_BUCKETS_DEF;
    localparam int SETTLE_CYCLES = 150;
    localparam int RANDOM_ITEMS  = 90;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idling;

    // one output point of the resampled curve
    typedef struct packed {
        logic [BW-1:0] idx;
        logic [CW-1:0] cnt;
        logic          eoc;
        logic          err;
    } t_curve_out;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [CIW-1:0]  i_cfg_index;
    logic [BW-1:0]   i_cfg_data;
    logic            i_in_valid;
    logic            o_in_stall;
    logic [CW-1:0]   i_curve_point;
    logic            o_out_valid;
    logic            i_out_stall;
    logic [BW-1:0]   o_bucket_index;
    logic [CW-1:0]   o_resampled_count;
    logic            o_end_of_curve;
    logic            o_ratio_error;

    miss_curve_resampler u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_curve_point     (i_curve_point),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_bucket_index    (o_bucket_index),
        .o_resampled_count (o_resampled_count),
        .o_end_of_curve    (o_end_of_curve),
        .o_ratio_error     (o_ratio_error)
    );

    // predictor state: live registers plus the block's curve state
    logic [BW-1:0] src_reg;
    logic [BW-1:0] dst_reg;
    logic [CW-1:0] prev_point;
    logic [BW-1:0] next_point_idx;
    logic [BW-1:0] held_ratio;

    t_curve_out expected_points[$];
    int         mismatches;
    int         points_sent;
    int         sender_idle_pct;
    int         receiver_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous cap on the run time
    initial begin
        #20_000_000;
        $display("miss_curve_resampler_tb failed");
        $finish;
    end

    // out-of-range counts: zero acts as one, anything above the max as the max
    function automatic int unsigned clamp_buckets(input logic [BW-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_BKT) return MAX_BKT;
        return v;
    endfunction

    function automatic void push_point(input int unsigned idx, input logic [CW-1:0] cnt,
                                       input logic eoc, input logic err);
        t_curve_out pt;
        pt.idx = BW'(idx);  // index wraps to the port width
        pt.cnt = cnt;
        pt.eoc = eoc;
        pt.err = err;
        expected_points.push_back(pt);
    endfunction

    // expected output points caused by one accepted source point
    task automatic resample_point(input logic [CW-1:0] p);
        int unsigned s, d, r, i, j, k;
        bit          down, err, closes_curve;
        logic [63:0] num;
        s = clamp_buckets(src_reg);
        d = clamp_buckets(dst_reg);
        down = (s >= d);
        err = down ? ((s % d) != 0) : ((d % s) != 0);
        i = next_point_idx;
        // ratio is latched at point 0 only; mode and end follow live registers
        if (i == 0) held_ratio = BW'(down ? s / d : d / s);
        r = (held_ratio == 0) ? 1 : held_ratio;
        closes_curve = (i >= s);
        if (down) begin
            if ((i % r) == 0 && (i / r) < d && !closes_curve) push_point(i / r, p, 1'b0, err);
        end else if (i >= 1) begin
            // split segment (prev, p) into r parts, rounded down
            j = i - 1;
            for (k = 0; k < r; k++) begin
                num = (64'(prev_point) * 64'(r - k) + 64'(p) * 64'(k)) / 64'(r);
                push_point(r * j + k, num[CW-1:0], 1'b0, err);
            end
        end
        if (closes_curve) begin
            push_point(d, p, 1'b1, err);
            next_point_idx = '0;
        end else begin
            next_point_idx = BW'(i + 1);
        end
        prev_point = p;
    endtask

    task automatic set_idling(input t_idling mode);
        case (mode)
            IDLE_NONE: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            IDLE_SENDER: begin
                sender_idle_pct = 68;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 68;
            end
            default: begin
                sender_idle_pct = 19;
                receiver_stall_pct = 19;
            end
        endcase
    endtask

    // send one source point; valid stays high after acceptance so that
    // back-to-back items never drop and raise it in one step
    task automatic send_point(input logic [CW-1:0] p);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_curve_point <= p;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        resample_point(p);
        points_sent++;
    endtask

    // hold the sender until all output has arrived and the block is quiet
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_buckets(input bit src_en, input logic [BW-1:0] src_v,
                                 input bit dst_en, input logic [BW-1:0] dst_v);
        if (src_en) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= mcr_pkg::CFG_SRC_BUCKETS;
            i_cfg_data  <= src_v;
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            src_reg = src_v;
        end
        if (dst_en) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= mcr_pkg::CFG_DST_BUCKETS;
            i_cfg_data  <= dst_v;
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            dst_reg = dst_v;
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CW-1:0] random_point();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return CW'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    // mostly small counts, sometimes zero or at or beyond the max
    function automatic logic [BW-1:0] random_buckets(input int unsigned hi);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? '0 : BW'($urandom_range(32, 63));
        return BW'($urandom_range(1, hi));
    endfunction

    // ---------------------------------------------------------------- tests

    // reset values 16/16 give plain 1:1 pass-through; curve left open
    task automatic test_reset_defaults();
        set_idling(IDLE_NONE);
        send_point('0);
        send_point('1);
        send_point($urandom());
        wait_drained();
    endtask

    // both counts zero act as one; first item closes the open curve
    task automatic test_zero_counts();
        write_buckets(1'b1, '0, 1'b1, '0);
        send_point($urandom());
        send_point('1);
        send_point('0);
        wait_drained();
    endtask

    // widest interpolation: one source bucket to 63 (taken as 32), 32 points per segment
    task automatic test_max_upsample();
        set_idling(IDLE_BOTH);
        write_buckets(1'b1, 6'd1, 1'b1, 6'd63);
        send_point('1);
        send_point('0);
        send_point('0);
        send_point('1);
        wait_drained();
    endtask

    // uneven ratios in both directions, includes dropped decimation points
    task automatic test_uneven_ratio();
        int n;
        set_idling(IDLE_RECEIVER);
        write_buckets(1'b1, 6'd3, 1'b1, 6'd2);
        for (n = 0; n < 4; n++) send_point(random_point());
        wait_drained();
        write_buckets(1'b1, 6'd2, 1'b1, 6'd5);
        for (n = 0; n < 3; n++) send_point(random_point());
        wait_drained();
    endtask

    // ratio latched at point 0 survives a source count change; index wraps
    task automatic test_ratio_change_mid_curve();
        int n;
        set_idling(IDLE_SENDER);
        write_buckets(1'b1, 6'd1, 1'b1, 6'd32);
        send_point(random_point());
        wait_drained();
        write_buckets(1'b1, 6'd3, 1'b0, '0);
        for (n = 0; n < 3; n++) send_point(random_point());
        wait_drained();
    endtask

    // random curves, mostly whole, some cut short before a new setting
    task automatic test_random_curves();
        int          curve_no;
        int          start_count;
        int          n_points;
        int          n;
        bit          src_en;
        bit          dst_en;
        curve_no = 0;
        start_count = points_sent;
        while (points_sent - start_count < RANDOM_ITEMS) begin
            set_idling(t_idling'(curve_no % 4));
            case ($urandom_range(0, 5))
                0: begin
                    src_en = 1'b1;
                    dst_en = 1'b0;
                end
                1: begin
                    src_en = 1'b0;
                    dst_en = 1'b1;
                end
                default: begin
                    src_en = 1'b1;
                    dst_en = 1'b1;
                end
            endcase
            write_buckets(src_en, random_buckets(6), dst_en, random_buckets(12));
            n_points = clamp_buckets(src_reg) + 1;
            // broken curve: stop early, next setting lands mid-curve
            if ($urandom_range(0, 7) == 0) n_points = $urandom_range(1, n_points - 1);
            for (n = 0; n < n_points; n++) send_point(random_point());
            wait_drained();
            curve_no++;
        end
    endtask

    // ---------------------------------------------------------------- checker

    always @(posedge i_clk) begin : check_results
        t_curve_out want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                $display("%0t: expected no item, actual idx %0d count %0d end %0b err %0b",
                         $time, o_bucket_index, o_resampled_count, o_end_of_curve,
                         o_ratio_error);
            end else begin
                want = expected_points.pop_front();
                if (o_bucket_index !== want.idx || o_resampled_count !== want.cnt ||
                    o_end_of_curve !== want.eoc || o_ratio_error !== want.err) begin
                    mismatches++;
                    $display("%0t: expected idx %0d count %0d end %0b err %0b,",
                             $time, want.idx, want.cnt, want.eoc, want.err,
                             " actual idx %0d count %0d end %0b err %0b",
                             o_bucket_index, o_resampled_count, o_end_of_curve,
                             o_ratio_error);
                end
            end
        end
        // receiver back-pressure for the next cycle
        i_out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // ---------------------------------------------------------------- main

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= mcr_pkg::CFG_SRC_BUCKETS;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_curve_point <= '0;
        i_out_stall   <= 1'b0;
        mismatches = 0;
        points_sent = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        // predictor mirrors the reset state
        src_reg = mcr_pkg::BUCKETS_RST;
        dst_reg = mcr_pkg::BUCKETS_RST;
        prev_point = '0;
        next_point_idx = '0;
        held_ratio = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        test_reset_defaults();
        test_zero_counts();
        test_max_upsample();
        test_uneven_ratio();
        test_ratio_change_mid_curve();
        test_random_curves();

        wait_drained();
        if (mismatches == 0)
            $display("miss_curve_resampler_tb passed");
        else
            $display("miss_curve_resampler_tb failed");
        $finish;
    end

endmodule
